// File: rtl/nqsc_pkg.sv
// shared types and constants for the n-queens solution counter
`default_nettype none
package nqsc_pkg;

	localparam int SIZE_W  = 4;
	localparam int COUNT_W = 7;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [SIZE_W-1:0]  SIZE_RESET = SIZE_W'(8);
	localparam int TDATA_W = 8;

	typedef struct packed {
		logic clear;
		logic act;
	} nqsc_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/n_queens_solution_counter_top.sv
// top level: search sequencer over a chain of row cells
// throughput: one search at a time; the next start is taken once the result is out
// the step rate is set by the active row cell, one placement or backtrack per cycle
// reset: board_size returns to 8, the search sits idle and no result is pending
`default_nettype none
module n_queens_solution_counter_top import nqsc_pkg::*; #(
	parameter int MAX_N = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [TDATA_W-1:0] s_tdata,   // [0] start_req
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic      [TDATA_W-1:0] m_tdata,   // [6:0] solution_count
	input  wire logic               cfg_we,
	input  wire logic [SIZE_W-1:0]  cfg_wdata
);

	localparam int LVL_W = $clog2(MAX_N + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	state_t             state_q;
	logic [SIZE_W-1:0]  board_size_q;
	logic [LVL_W-1:0]   n_q;
	logic [LVL_W-1:0]   level_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] result_q;
	logic               m_tvalid_q;
	logic [LVL_W-1:0]   n_start;
	logic [MAX_N-1:0]   board_mask;
	logic [MAX_N-1:0]   act_vec;
	logic [MAX_N-1:0]   found_vec;
	logic               step_found;
	logic               start;
	logic               out_free;
	logic [MAX_N-1:0]   col_w [MAX_N+1];
	logic [MAX_N-1:0]   ld_w  [MAX_N+1];
	logic [MAX_N-1:0]   rd_w  [MAX_N+1];

	assign start    = s_tvalid && s_tready && s_tdata[0];
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		if ({1'b0, board_size_q} > (SIZE_W + 1)'(MAX_N)) begin
			n_start = LVL_W'(MAX_N);
		end else begin
			n_start = LVL_W'(board_size_q);
		end
	end

	assign col_w[0] = '0;
	assign ld_w[0]  = '0;
	assign rd_w[0]  = '0;

	for (genvar i = 0; i < MAX_N; i++) begin : g_row
		nqsc_ctrl_t ctrl;
		assign board_mask[i] = (LVL_W'(i) < n_q);
		assign act_vec[i]    = (state_q == ST_RUN) && (level_q == LVL_W'(i));
		assign ctrl.clear    = start;
		assign ctrl.act      = act_vec[i];
		nqsc_cell #(.MAX_N(MAX_N)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.board_mask (board_mask),
			.col_in     (col_w[i]),
			.ld_in      (ld_w[i]),
			.rd_in      (rd_w[i]),
			.col_out    (col_w[i+1]),
			.ld_out     (ld_w[i+1]),
			.rd_out     (rd_w[i+1]),
			.found      (found_vec[i])
		);
	end

	assign step_found = |(found_vec & act_vec);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			board_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			n_q        <= '0;
			level_q    <= '0;
			count_q    <= '0;
			result_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_HOLD && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						n_q     <= n_start;
						level_q <= '0;
						if (n_start == '0) begin
							count_q <= COUNT_W'(1);
							state_q <= ST_HOLD;
						end else begin
							count_q <= '0;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (step_found) begin
						if (level_q == n_q - LVL_W'(1)) begin
							if (count_q != COUNT_MAX) begin
								count_q <= count_q + COUNT_W'(1);
							end
						end else begin
							level_q <= level_q + LVL_W'(1);
						end
					end else if (level_q == '0) begin
						state_q <= ST_HOLD;
					end else begin
						level_q <= level_q - LVL_W'(1);
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						result_q <= count_q;
						level_q  <= '0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TDATA_W'(result_q);

	a_level_in_board: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (level_q < n_q))
		else $error("search level beyond board size");

	a_hold_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD && out_free) |=> (m_tvalid && state_q == ST_IDLE))
		else $error("finished search did not present its result");

	a_idle_level_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (level_q == '0))
		else $error("search level not cleared after a search");

	a_last_row_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start) |-> (col_w[MAX_N] == '0 && ld_w[MAX_N] == '0 && rd_w[MAX_N] == '0))
		else $error("row chain not cleared at start");

endmodule
`default_nettype wire

// File: rtl/nqsc_cell.sv
// one board row: holds its queen and passes attack masks to the next row
`default_nettype none
module nqsc_cell import nqsc_pkg::*; #(
	parameter int MAX_N = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire nqsc_ctrl_t       ctrl,
	input  wire logic [MAX_N-1:0] board_mask,
	input  wire logic [MAX_N-1:0] col_in,
	input  wire logic [MAX_N-1:0] ld_in,
	input  wire logic [MAX_N-1:0] rd_in,
	output logic      [MAX_N-1:0] col_out,
	output logic      [MAX_N-1:0] ld_out,
	output logic      [MAX_N-1:0] rd_out,
	output logic                  found
);

	logic [MAX_N-1:0] pos_q;
	logic [MAX_N-1:0] col_q;
	logic [MAX_N-1:0] ld_q;
	logic [MAX_N-1:0] rd_q;
	logic [MAX_N-1:0] free;
	logic [MAX_N-1:0] above;
	logic [MAX_N-1:0] cand;
	logic [MAX_N-1:0] pick;
	logic [MAX_N-1:0] pos_next;

	always_comb begin
		free = board_mask & ~(col_in | ld_in | rd_in);
		// columns to the right of the current queen
		if (pos_q == '0) begin
			above = '1;
		end else begin
			above = ~((pos_q - MAX_N'(1)) | pos_q);
		end
		cand     = free & above;
		pick     = cand & (~cand + MAX_N'(1));
		found    = |cand;
		pos_next = found ? pick : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			col_q <= '0;
			ld_q  <= '0;
			rd_q  <= '0;
		end else if (ctrl.clear) begin
			pos_q <= '0;
			col_q <= '0;
			ld_q  <= '0;
			rd_q  <= '0;
		end else if (ctrl.act) begin
			pos_q <= pos_next;
			col_q <= col_in | pos_next;
			ld_q  <= (ld_in | pos_next) << 1;
			rd_q  <= (rd_in | pos_next) >> 1;
		end
	end

	assign col_out = col_q;
	assign ld_out  = ld_q;
	assign rd_out  = rd_q;

endmodule
`default_nettype wire
